>>> design/svm_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed-point constants of the space vector modulator.
package svm_pkg;

   // Width of the normalized Q1.15 voltage inputs.
   localparam int VOLT_W = 16;

   // Width of the compare values on the result channel.
   localparam int DUTY_W = 16;

   // Width of the Q3.15 on-time operands, with headroom for the sector sums.
   localparam int X_W = 18;

   // Width of a voltage times a sqrt3 constant.
   localparam int KPROD_W = X_W + VOLT_W;

   // 1/sqrt3 and 2/sqrt3 with 16 fraction bits, truncated.
   localparam logic signed [X_W-1:0] SQRT3_INV  = 18'sd37837;
   localparam logic signed [X_W-1:0] SQRT3_INV2 = 18'sd75674;

   // Period after reset, cut down to the period register width where used.
   localparam logic [31:0] PERIOD_RESET = 32'd4200;

   // Sector numbers of the hexagon.
   typedef enum logic [2:0] {
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5,
      SECTOR_6 = 3'd6
   } sector_type;

endpackage

>>> design/svm_req_if.sv
`timescale 1ns / 1ps
// Request channel carrying one alpha/beta voltage vector.
interface svm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [svm_pkg::VOLT_W-1:0]   alpha_voltage;
   logic signed [svm_pkg::VOLT_W-1:0]   beta_voltage;

   modport source (output valid, output alpha_voltage, output beta_voltage, input ready);
   modport sink (input valid, input alpha_voltage, input beta_voltage, output ready);
endinterface

>>> design/svm_rsp_if.sv
`timescale 1ns / 1ps
// Result channel carrying three phase compare values, the sector and the clamp flag.
interface svm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [svm_pkg::DUTY_W-1:0]   duty_a;
   logic [svm_pkg::DUTY_W-1:0]   duty_b;
   logic [svm_pkg::DUTY_W-1:0]   duty_c;
   svm_pkg::sector_type          sector;
   logic                         overmodulated;

   modport source (output valid, output duty_a, output duty_b, output duty_c,
                   output sector, output overmodulated, input ready);
   modport sink (input valid, input duty_a, input duty_b, input duty_c,
                 input sector, input overmodulated, output ready);
endinterface

>>> design/svm_sector.sv
`timescale 1ns / 1ps
// Two pipeline stages: beta scaling by the sqrt3 constants, then sector and on-time operands.
module svm_angle_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [svm_pkg::VOLT_W-1:0]  alpha,
   input  logic signed [svm_pkg::VOLT_W-1:0]  beta,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [svm_pkg::X_W-1:0]     x_u,
   output logic signed [svm_pkg::X_W-1:0]     x_v,
   output svm_pkg::sector_type                sector
);

   localparam int KW = svm_pkg::KPROD_W;
   localparam int XW = svm_pkg::X_W;

   logic                  s1_valid_ff;
   logic                  s1_ready;
   logic                  s2_valid_ff;
   logic                  s2_ready;

   logic signed [XW-1:0]  alpha_ff;
   logic signed [XW-1:0]  alpha_in;
   logic signed [KW-1:0]  prod3_ff;
   logic signed [KW-1:0]  prod3_in;
   logic signed [KW-1:0]  prod23_ff;
   logic signed [KW-1:0]  prod23_in;

   logic signed [KW-1:0]  adj3;
   logic signed [KW-1:0]  adj23;
   logic signed [XW-1:0]  b3;
   logic signed [XW-1:0]  b23;
   logic signed [XW-1:0]  neg_b3;
   logic                  beta_neg;

   logic signed [XW-1:0]  x_u_ff;
   logic signed [XW-1:0]  x_u_in;
   logic signed [XW-1:0]  x_v_ff;
   logic signed [XW-1:0]  x_v_in;
   svm_pkg::sector_type   sector_ff;
   svm_pkg::sector_type   sector_in;

   // Each stage takes a new request when it is empty or its content moves on.
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Stage 1: beta times 1/sqrt3 and 2/sqrt3.
   always_comb begin
      alpha_in  = XW'(alpha);
      prod3_in  = svm_pkg::SQRT3_INV * KW'(beta);
      prod23_in = svm_pkg::SQRT3_INV2 * KW'(beta);
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         alpha_ff  <= alpha_in;
         prod3_ff  <= prod3_in;
         prod23_ff <= prod23_in;
      end
   end

   // Stage 2: drop 16 fraction bits toward zero, pick the sector and form the operands.
   always_comb begin
      adj3     = prod3_ff + (prod3_ff[KW-1] ? KW'(65535) : KW'(0));
      adj23    = prod23_ff + (prod23_ff[KW-1] ? KW'(65535) : KW'(0));
      b3       = adj3[KW-1:16];
      b23      = adj23[KW-1:16];
      neg_b3   = -b3;
      beta_neg = b3[XW-1] || prod3_ff[KW-1];

      if (!beta_neg) begin
         if (!alpha_ff[XW-1]) begin
            sector_in = (b3 > alpha_ff) ? svm_pkg::SECTOR_2 : svm_pkg::SECTOR_1;
         end else begin
            sector_in = (neg_b3 > alpha_ff) ? svm_pkg::SECTOR_3 : svm_pkg::SECTOR_2;
         end
      end else begin
         if (!alpha_ff[XW-1]) begin
            sector_in = (neg_b3 > alpha_ff) ? svm_pkg::SECTOR_5 : svm_pkg::SECTOR_6;
         end else begin
            sector_in = (b3 > alpha_ff) ? svm_pkg::SECTOR_4 : svm_pkg::SECTOR_5;
         end
      end

      case (sector_in)
         svm_pkg::SECTOR_1: begin
            x_u_in = alpha_ff - b3;
            x_v_in = b23;
         end
         svm_pkg::SECTOR_2: begin
            x_u_in = alpha_ff + b3;
            x_v_in = b3 - alpha_ff;
         end
         svm_pkg::SECTOR_3: begin
            x_u_in = b23;
            x_v_in = neg_b3 - alpha_ff;
         end
         svm_pkg::SECTOR_4: begin
            x_u_in = b3 - alpha_ff;
            x_v_in = -b23;
         end
         svm_pkg::SECTOR_5: begin
            x_u_in = neg_b3 - alpha_ff;
            x_v_in = alpha_ff - b3;
         end
         svm_pkg::SECTOR_6: begin
            x_u_in = -b23;
            x_v_in = alpha_ff + b3;
         end
         default: begin
            x_u_in = '0;
            x_v_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         x_u_ff    <= x_u_in;
         x_v_ff    <= x_v_in;
         sector_ff <= sector_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign x_u       = x_u_ff;
   assign x_v       = x_v_ff;
   assign sector    = sector_ff;

endmodule

>>> design/svm_ontime.sv
`timescale 1ns / 1ps
// Three pipeline stages: on-time products with the period, their scaling, and the leading phase.
module svm_ontime #(
   parameter int PERIOD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [PERIOD_BITS-1:0]             period,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [svm_pkg::X_W-1:0]     x_u,
   input  logic signed [svm_pkg::X_W-1:0]     x_v,
   input  svm_pkg::sector_type                sector_i,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [PERIOD_BITS+4:0]      lead,
   output logic signed [PERIOD_BITS+4:0]      first_step,
   output logic signed [PERIOD_BITS+4:0]      both_steps,
   output svm_pkg::sector_type                sector_o
);

   localparam int XW = svm_pkg::X_W;
   localparam int PW = XW + PERIOD_BITS + 1;
   localparam int TW = PW - 15;
   localparam int SW = PERIOD_BITS + 5;

   logic                  s3_valid_ff;
   logic                  s3_ready;
   logic                  s4_valid_ff;
   logic                  s4_ready;
   logic                  s5_valid_ff;
   logic                  s5_ready;

   logic signed [PERIOD_BITS:0]  period_s;
   logic signed [SW-1:0]         period_w;

   logic signed [PW-1:0]  prod_u_ff;
   logic signed [PW-1:0]  prod_u_in;
   logic signed [PW-1:0]  prod_v_ff;
   logic signed [PW-1:0]  prod_v_in;
   svm_pkg::sector_type   sec3_ff;

   logic signed [PW-1:0]  adj_u;
   logic signed [PW-1:0]  adj_v;
   logic signed [TW-1:0]  t_u;
   logic signed [TW-1:0]  t_v;
   logic signed [SW-1:0]  step_ff;
   logic signed [SW-1:0]  step_in;
   logic signed [SW-1:0]  uv_ff;
   logic signed [SW-1:0]  uv_in;
   svm_pkg::sector_type   sec4_ff;

   logic signed [SW-1:0]  total;
   logic signed [SW-1:0]  total_adj;
   logic signed [SW-1:0]  lead_ff;
   logic signed [SW-1:0]  lead_in;
   logic signed [SW-1:0]  step5_ff;
   logic signed [SW-1:0]  uv5_ff;
   svm_pkg::sector_type   sec5_ff;

   assign period_s = signed'({1'b0, period});
   assign period_w = SW'(period_s);

   // Stage handshake: a stage loads when empty or when its content moves on.
   assign s5_ready = !s5_valid_ff || out_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) begin
            s3_valid_ff <= in_valid;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (s5_ready) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   // Stage 3: both operands times the period.
   always_comb begin
      prod_u_in = PW'(x_u) * PW'(period_s);
      prod_v_in = PW'(x_v) * PW'(period_s);
   end

   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) begin
         prod_u_ff <= prod_u_in;
         prod_v_ff <= prod_v_in;
         sec3_ff   <= sector_i;
      end
   end

   // Stage 4: drop 15 fraction bits toward zero; odd sectors step by the first on-time.
   always_comb begin
      adj_u = prod_u_ff + (prod_u_ff[PW-1] ? PW'(32767) : PW'(0));
      adj_v = prod_v_ff + (prod_v_ff[PW-1] ? PW'(32767) : PW'(0));
      t_u   = adj_u[PW-1:15];
      t_v   = adj_v[PW-1:15];
      uv_in = SW'(t_u) + SW'(t_v);
      case (sec3_ff)
         svm_pkg::SECTOR_1, svm_pkg::SECTOR_3, svm_pkg::SECTOR_5: begin
            step_in = SW'(t_u);
         end
         default: begin
            step_in = SW'(t_v);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         step_ff <= step_in;
         uv_ff   <= uv_in;
         sec4_ff <= sec3_ff;
      end
   end

   // Stage 5: leading phase is half of period plus both on-times, toward zero.
   always_comb begin
      total     = period_w + uv_ff;
      total_adj = total + SW'(total[SW-1]);
      lead_in   = {total_adj[SW-1], total_adj[SW-1:1]};
   end

   always_ff @(posedge clock) begin
      if (s5_ready && s4_valid_ff) begin
         lead_ff  <= lead_in;
         step5_ff <= step_ff;
         uv5_ff   <= uv_ff;
         sec5_ff  <= sec4_ff;
      end
   end

   assign out_valid  = s5_valid_ff;
   assign lead       = lead_ff;
   assign first_step = step5_ff;
   assign both_steps = uv5_ff;
   assign sector_o   = sec5_ff;

endmodule

>>> design/svm_phase.sv
`timescale 1ns / 1ps
// Output stage: phase routing by sector, clamping to the period and the result register.
module svm_phase #(
   parameter int PERIOD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [PERIOD_BITS-1:0]             period,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [PERIOD_BITS+4:0]      lead,
   input  logic signed [PERIOD_BITS+4:0]      first_step,
   input  logic signed [PERIOD_BITS+4:0]      both_steps,
   input  svm_pkg::sector_type                sector_i,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [svm_pkg::DUTY_W-1:0]         duty_a,
   output logic [svm_pkg::DUTY_W-1:0]         duty_b,
   output logic [svm_pkg::DUTY_W-1:0]         duty_c,
   output svm_pkg::sector_type                sector_o,
   output logic                               overmodulated
);

   localparam int SW = PERIOD_BITS + 5;
   localparam int DW = svm_pkg::DUTY_W;
   localparam int CW = (SW > DW) ? SW : DW;

   logic                  valid_ff;
   logic signed [SW-1:0]  period_w;
   logic signed [SW-1:0]  second;
   logic signed [SW-1:0]  third;
   logic signed [SW-1:0]  raw [3];
   logic signed [CW-1:0]  wide [3];
   logic [DW-1:0]         duty_in [3];
   logic [DW-1:0]         duty_ff [3];
   logic                  ovm_in;
   logic                  ovm_ff;
   svm_pkg::sector_type   sector_ff;

   assign period_w = SW'(signed'({1'b0, period}));
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Place the leading phase and its two followers by sector, then saturate.
   always_comb begin
      second = lead - first_step;
      third  = lead - both_steps;
      case (sector_i)
         svm_pkg::SECTOR_1: begin
            raw[0] = lead;   raw[1] = second; raw[2] = third;
         end
         svm_pkg::SECTOR_2: begin
            raw[0] = second; raw[1] = lead;   raw[2] = third;
         end
         svm_pkg::SECTOR_3: begin
            raw[0] = third;  raw[1] = lead;   raw[2] = second;
         end
         svm_pkg::SECTOR_4: begin
            raw[0] = third;  raw[1] = second; raw[2] = lead;
         end
         svm_pkg::SECTOR_5: begin
            raw[0] = second; raw[1] = third;  raw[2] = lead;
         end
         default: begin
            raw[0] = lead;   raw[1] = third;  raw[2] = second;
         end
      endcase

      ovm_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (raw[i] < 0) begin
            wide[i] = '0;
            ovm_in  = 1'b1;
         end else if (raw[i] > period_w) begin
            wide[i] = CW'(period_w);
            ovm_in  = 1'b1;
         end else begin
            wide[i] = CW'(raw[i]);
         end
         duty_in[i] = wide[i][DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         duty_ff   <= duty_in;
         ovm_ff    <= ovm_in;
         sector_ff <= sector_i;
      end
   end

   assign out_valid     = valid_ff;
   assign duty_a        = duty_ff[0];
   assign duty_b        = duty_ff[1];
   assign duty_c        = duty_ff[2];
   assign sector_o      = sector_ff;
   assign overmodulated = ovm_ff;

endmodule

>>> design/space_vector_modulation.sv
`timescale 1ns / 1ps
// Six-sector space vector PWM: top level with the period register and the pipeline.
//
//   Channel    Direction  Handshake                   Carries
//   req_chan   in         valid/ready                 alpha_voltage, beta_voltage (Q1.15)
//   rsp_chan   out        valid/ready                 duty_a, duty_b, duty_c, sector, overmodulated
//   psel ...   in/out     APB setup + access, pready  pwm_period at byte address 0
//
// A request goes through six register stages, in svm_angle_stage, svm_ontime and the result
// register of svm_phase, and one request can be accepted in every cycle while results are taken.
// The depth is set by the two multiplier stages (beta by the sqrt3 constants, operands by
// the period) and the adders between them. Synchronous reset empties the pipeline and
// loads the period with 4200. When the result is not taken, each stage holds until the one
// after it frees up, so bubbles close and req_chan.ready falls only when every stage is full.
module space_vector_modulation #(
   parameter int PERIOD_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   svm_req_if.sink       req_chan,
   svm_rsp_if.source     rsp_chan,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam int XW = svm_pkg::X_W;
   localparam int SW = PERIOD_BITS + 5;

   // Register index carried in the word address bit.
   localparam logic REG_PWM_PERIOD = 1'b0;

   logic [PERIOD_BITS-1:0]  period_ff;
   logic [PERIOD_BITS-1:0]  period_in;
   logic                    csr_write;

   logic                    sec_valid;
   logic                    sec_ready;
   logic signed [XW-1:0]    sec_x_u;
   logic signed [XW-1:0]    sec_x_v;
   svm_pkg::sector_type     sec_sector;

   logic                    ont_valid;
   logic                    ont_ready;
   logic signed [SW-1:0]    ont_lead;
   logic signed [SW-1:0]    ont_step;
   logic signed [SW-1:0]    ont_both;
   svm_pkg::sector_type     ont_sector;

   // Configuration port: zero wait states, period register at word zero.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == REG_PWM_PERIOD);
   assign period_in = pwdata[PERIOD_BITS-1:0];
   assign prdata    = (paddr[2] == REG_PWM_PERIOD) ? 32'(period_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= svm_pkg::PERIOD_RESET[PERIOD_BITS-1:0];
      end else if (csr_write) begin
         period_ff <= period_in;
      end
   end

   // Sector choice and on-time operands.
   svm_angle_stage u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .alpha     (req_chan.alpha_voltage),
      .beta      (req_chan.beta_voltage),
      .out_valid (sec_valid),
      .out_ready (sec_ready),
      .x_u       (sec_x_u),
      .x_v       (sec_x_v),
      .sector    (sec_sector)
   );

   // On-times scaled by the period and the leading phase.
   svm_ontime #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_ontime (
      .clock      (clock),
      .reset      (reset),
      .period     (period_ff),
      .in_valid   (sec_valid),
      .in_ready   (sec_ready),
      .x_u        (sec_x_u),
      .x_v        (sec_x_v),
      .sector_i   (sec_sector),
      .out_valid  (ont_valid),
      .out_ready  (ont_ready),
      .lead       (ont_lead),
      .first_step (ont_step),
      .both_steps (ont_both),
      .sector_o   (ont_sector)
   );

   // Phase routing, saturation and the result register.
   svm_phase #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_phase (
      .clock         (clock),
      .reset         (reset),
      .period        (period_ff),
      .in_valid      (ont_valid),
      .in_ready      (ont_ready),
      .lead          (ont_lead),
      .first_step    (ont_step),
      .both_steps    (ont_both),
      .sector_i      (ont_sector),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .duty_a        (rsp_chan.duty_a),
      .duty_b        (rsp_chan.duty_b),
      .duty_c        (rsp_chan.duty_c),
      .sector_o      (rsp_chan.sector),
      .overmodulated (rsp_chan.overmodulated)
   );

   // The request side only stalls when the result register is full and not taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("request stalled while the result register could move");

   // A clamped result always shows at least one phase at zero or at the period.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.overmodulated) |->
         (rsp_chan.duty_a == '0 || rsp_chan.duty_a == 16'(period_ff) ||
          rsp_chan.duty_b == '0 || rsp_chan.duty_b == 16'(period_ff) ||
          rsp_chan.duty_c == '0 || rsp_chan.duty_c == 16'(period_ff)))
      else $error("overmodulation flagged without a saturated phase");

   // With a zero period every phase is zero and nothing is clamped.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && period_ff == '0) |->
         (rsp_chan.duty_a == '0 && rsp_chan.duty_b == '0 &&
          rsp_chan.duty_c == '0 && !rsp_chan.overmodulated))
      else $error("nonzero duty with a zero period");

   // The sector on a result is always one of the six.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.sector >= 3'd1 && rsp_chan.sector <= 3'd6))
      else $error("result sector out of range");

endmodule
